### hw/rtl/assert_macros.svh
// Assertion macros shared by the match list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be seen high outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: condition must never hold");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication violated");

`endif

### hw/rtl/tsml_pkg.sv
// Shared constants, types and helpers of the threshold sorted match list.
`default_nettype none

package tsml_pkg;

   // List and grid sizing
   localparam int unsigned MAX_MATCHES  = 32;
   localparam int unsigned CELL_COUNT   = 4096;
   localparam int unsigned RESULT_LIMIT = 32;

   // Field widths
   localparam int unsigned SCORE_W  = 16;
   localparam int unsigned CELL_W   = 12;
   localparam int unsigned COLS_W   = 12;
   localparam int unsigned SCALE_W  = 16;
   localparam int unsigned POS_W    = 16;
   localparam int unsigned TOTAL_W  = 6;
   localparam int unsigned CNT_W    = $clog2(MAX_MATCHES + 1);
   localparam int unsigned PROD_W   = CELL_W + SCALE_W;
   localparam int unsigned FRAC_SHIFT = 4;
   localparam int unsigned DIV_CNT_W  = $clog2(CELL_W + 1);

   // Stream payload widths
   localparam int unsigned REQ_FIELD_W = SCORE_W + 2 * CELL_W;
   localparam int unsigned REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int unsigned RSP_FIELD_W = 4 * POS_W + SCORE_W + TOTAL_W + 1;
   localparam int unsigned RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // Register file
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] REG_CONF_THRESHOLD = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SORT_ENABLE    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_GRID_COLUMNS   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_AX       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_AY       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_BX       = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_BY       = 3'd6;

   localparam logic [SCORE_W-1:0] THRESHOLD_RST = 16'd32768;
   localparam logic [COLS_W-1:0]  COLUMNS_RST   = 12'd80;
   localparam logic [SCALE_W-1:0] SCALE_RST     = 16'd2048;

   // One list entry
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [CELL_W-1:0]  cell_a;
      logic [CELL_W-1:0]  cell_b;
   } entry_type;

   // Controller to datapath commands
   typedef struct packed {
      logic take;       // input beat accepted
      logic div_start;  // start coordinate division for head entry
      logic mul_load;   // register scaled products
      logic out_load;   // load result register
      logic out_empty;  // result is the empty-list marker
      logic out_last;   // result closes the run
      logic pop;        // drop head entry after it was sent
      logic clear;      // run finished, empty the list
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic             empty;
      logic [CNT_W-1:0] count;
      logic             div_done;
   } dp_stat_type;

   // Q20.8 product to Q12.4 pixels, truncated and saturated
   function automatic logic [POS_W-1:0] to_pixels(input logic [PROD_W-1:0] prod);
      logic [PROD_W-1:0] shifted;
      shifted = prod >> FRAC_SHIFT;
      if (|(shifted >> POS_W)) begin
         to_pixels = '1;
      end else begin
         to_pixels = shifted[POS_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

### hw/rtl/tsml_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module tsml_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [tsml_pkg::CELL_W-1:0] dividend,
   input  wire logic [tsml_pkg::COLS_W-1:0] divisor,
   output logic      [tsml_pkg::CELL_W-1:0] quotient,
   output logic      [tsml_pkg::CELL_W-1:0] remainder,
   output logic                            done
);
   import tsml_pkg::*;

   logic [CELL_W-1:0]    quo_ff, quo_in;
   logic [CELL_W-1:0]    rem_ff, rem_in;
   logic [COLS_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CELL_W:0]      trial;
   logic                 fits;

   // One restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[CELL_W-1]};
      fits   = trial >= (CELL_W + 1)'(dvs_ff);
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = DIV_CNT_W'(CELL_W);
      end else if (cnt_ff != '0) begin
         quo_in = {quo_ff[CELL_W-2:0], fits};
         rem_in = fits ? CELL_W'(trial - (CELL_W + 1)'(dvs_ff)) : trial[CELL_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = (cnt_ff == '0);

endmodule

`default_nettype wire

### hw/rtl/tsml_ctrl.sv
// Controller: accepts items, then sequences the emission of the list.
`default_nettype none

module tsml_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic                       req_tlast,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   input  wire tsml_pkg::dp_stat_type       stat,
   output tsml_pkg::ctrl_cmd_type           cmd
);
   import tsml_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_LOAD  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_SEND  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             at_last;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_SEND);
   assign at_last    = (left_ff == CNT_W'(1));

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      cmd      = '0;
      cmd.take = req_tvalid && req_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.take && req_tlast) begin
               state_in = S_START;
            end
         end
         S_START: begin
            // results to send: one marker when empty, else entries up to the cap
            if (stat.empty) begin
               left_in = CNT_W'(1);
            end else if (32'(stat.count) > RESULT_LIMIT) begin
               left_in = CNT_W'(RESULT_LIMIT);
            end else begin
               left_in = stat.count;
            end
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (stat.empty) begin
               cmd.out_load  = 1'b1;
               cmd.out_empty = 1'b1;
               cmd.out_last  = at_last;
               state_in      = S_SEND;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.mul_load = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.out_load = 1'b1;
            cmd.out_last = at_last;
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (rsp_tready) begin
               if (at_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  cmd.pop  = 1'b1;
                  left_in  = left_ff - CNT_W'(1);
                  state_in = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
      end
   end

`include "assert_macros.svh"

   `ASSERT_NEVER(a_busy_both_sides, clock, reset, req_tready && rsp_tvalid)
   `ASSERT_NEVER(a_send_with_nothing_left, clock, reset, rsp_tvalid && (left_ff == '0))

endmodule

`default_nettype wire

### hw/rtl/tsml_dp.sv
// Datapath: registers, insertion cell row, dividers, scaling and result register.
`default_nettype none

module tsml_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [tsml_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [tsml_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [tsml_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire tsml_pkg::ctrl_cmd_type           cmd,
   output tsml_pkg::dp_stat_type                 stat,
   output logic      [tsml_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);
   import tsml_pkg::*;

   // Configuration registers
   logic [SCORE_W-1:0] thr_ff;
   logic               sort_ff;
   logic [COLS_W-1:0]  cols_ff;
   logic [SCALE_W-1:0] sax_ff, say_ff, sbx_ff, sby_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THRESHOLD_RST;
         sort_ff <= 1'b1;
         cols_ff <= COLUMNS_RST;
         sax_ff  <= SCALE_RST;
         say_ff  <= SCALE_RST;
         sbx_ff  <= SCALE_RST;
         sby_ff  <= SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_CONF_THRESHOLD: thr_ff  <= csr_wdata[SCORE_W-1:0];
            REG_SORT_ENABLE:    sort_ff <= csr_wdata[0];
            REG_GRID_COLUMNS:   cols_ff <= csr_wdata[COLS_W-1:0];
            REG_SCALE_AX:       sax_ff  <= csr_wdata[SCALE_W-1:0];
            REG_SCALE_AY:       say_ff  <= csr_wdata[SCALE_W-1:0];
            REG_SCALE_BX:       sbx_ff  <= csr_wdata[SCALE_W-1:0];
            REG_SCALE_BY:       sby_ff  <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Input beat unpacking and keep decision
   entry_type  new_entry;
   logic       keep;

   assign new_entry.score  = req_tdata[SCORE_W-1:0];
   assign new_entry.cell_a = req_tdata[SCORE_W +: CELL_W];
   assign new_entry.cell_b = req_tdata[SCORE_W + CELL_W +: CELL_W];
   assign keep = cmd.take && (new_entry.score >= thr_ff) &&
                 (32'(new_entry.cell_a) < CELL_COUNT) &&
                 (32'(new_entry.cell_b) < CELL_COUNT);

   // Cell row: each cell compares against the incoming score
   entry_type        row_ff [MAX_MATCHES];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [MAX_MATCHES-1:0] gt;
   logic [MAX_MATCHES-1:0] shift_dn;
   logic             found;
   logic             full;

   for (genvar i = 0; i < MAX_MATCHES; i++) begin : g_cell
      assign gt[i] = sort_ff && (CNT_W'(i) < count_ff) &&
                     (new_entry.score > row_ff[i].score);
      if (i == 0) begin : g_head
         assign shift_dn[i] = 1'b0;
      end else begin : g_tail
         assign shift_dn[i] = |gt[i-1:0];
      end
   end

   assign found = |gt;
   assign full  = (32'(count_ff) >= MAX_MATCHES);

   // Insert shifts the cells below the slot; pop moves the row up by one
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_MATCHES; i++) begin
         if (cmd.pop) begin
            if (i < MAX_MATCHES - 1) begin
               row_ff[i] <= row_ff[i+1];
            end
         end else if (keep) begin
            if (shift_dn[i]) begin
               if (i > 0) begin
                  row_ff[i] <= row_ff[i-1];
               end
            end else if (gt[i] || (!found && (CNT_W'(i) == count_ff))) begin
               row_ff[i] <= new_entry;
            end
         end
      end
   end

   // Fill count and overflow flag
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      priority if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (keep) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Column and row of both cells, zero columns counts as one
   logic [COLS_W-1:0] cols_eff;
   logic [CELL_W-1:0] quo_a, rem_a, quo_b, rem_b;
   logic              done_a, done_b;

   assign cols_eff = (cols_ff == '0) ? COLS_W'(1) : cols_ff;

   tsml_div u_div_a (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (row_ff[0].cell_a),
      .divisor   (cols_eff),
      .quotient  (quo_a),
      .remainder (rem_a),
      .done      (done_a)
   );

   tsml_div u_div_b (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (row_ff[0].cell_b),
      .divisor   (cols_eff),
      .quotient  (quo_b),
      .remainder (rem_b),
      .done      (done_b)
   );

   // Scale products, one multiplier per coordinate
   logic [PROD_W-1:0] pax_ff, pay_ff, pbx_ff, pby_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         pax_ff <= PROD_W'(rem_a) * PROD_W'(sax_ff);
         pay_ff <= PROD_W'(quo_a) * PROD_W'(say_ff);
         pbx_ff <= PROD_W'(rem_b) * PROD_W'(sbx_ff);
         pby_ff <= PROD_W'(quo_b) * PROD_W'(sby_ff);
      end
   end

   // Result register
   logic [POS_W-1:0]   oax_ff, oay_ff, obx_ff, oby_ff;
   logic [SCORE_W-1:0] oscore_ff;
   logic [TOTAL_W-1:0] ototal_ff;
   logic               ovalid_ff, oovf_ff, olast_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         oovf_ff  <= ovf_ff;
         olast_ff <= cmd.out_last;
         if (cmd.out_empty) begin
            oax_ff    <= '0;
            oay_ff    <= '0;
            obx_ff    <= '0;
            oby_ff    <= '0;
            oscore_ff <= '0;
            ototal_ff <= '0;
            ovalid_ff <= 1'b0;
         end else begin
            oax_ff    <= to_pixels(pax_ff);
            oay_ff    <= to_pixels(pay_ff);
            obx_ff    <= to_pixels(pbx_ff);
            oby_ff    <= to_pixels(pby_ff);
            oscore_ff <= row_ff[0].score;
            ototal_ff <= TOTAL_W'(count_ff);
            ovalid_ff <= 1'b1;
         end
      end
   end

   assign rsp_tdata = RSP_TDATA_W'({oovf_ff, ototal_ff, oscore_ff,
                                    oby_ff, obx_ff, oay_ff, oax_ff});
   assign rsp_tuser = ovalid_ff;
   assign rsp_tlast = olast_ff;

   assign stat.empty    = (count_ff == '0);
   assign stat.count    = count_ff;
   assign stat.div_done = done_a && done_b;

`include "assert_macros.svh"

   `ASSERT_NEVER(a_count_bound, clock, reset, 32'(count_ff) > MAX_MATCHES)
   `ASSERT_NEXT(a_count_hold, clock, reset, !cmd.take && !cmd.clear, $stable(count_ff))

endmodule

`default_nettype wire

### hw/rtl/threshold_sorted_match_list_top.sv
// Top level of the threshold sorted match list.
`default_nettype none

// Keeps match candidates whose score reaches conf_threshold in a list of up to
// MAX_MATCHES entries, sorted by descending score (ties after earlier ones) or
// in arrival order, and on the beat marked tlast sends every entry as one
// result beat with pixel coordinates, then empties the list. An insert never
// stalls the input: the list is a row of compare-and-shift cells. After a
// final beat the block takes no input until the last result beat leaves.
// Each run begins with a setup state; each result then passes through a load
// state that starts the bit-serial column/row dividers of 12 steps, the divide
// state, which at its end also registers the scaled products, a format state
// and the send state, which waits on rsp_tready. An empty list yields one
// beat with tuser low. The user must write registers through the csr port
// only while the block is idle; the block itself does not enforce this.
module threshold_sorted_match_list_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration
   input  wire logic                             csr_we,
   input  wire logic [tsml_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [tsml_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // input stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // score[15:0], cell_a[27:16], cell_b[39:28]
   input  wire logic [tsml_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                             req_tlast,
   // result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // pos_ax[15:0], pos_ay[31:16], pos_bx[47:32], pos_by[63:48],
   // score_out[79:64], match_total[85:80], overflowed[86], zero[87]
   output logic      [tsml_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // entry_valid[0]
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);
   import tsml_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   tsml_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tsml_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

`default_nettype wire
